/* rtl/core/ras_pkg.sv */
package ras_pkg;

    // Default sizing
    localparam int unsigned DEPTH_DEF      = 1024;
    localparam int unsigned VALUE_BITS_DEF = 32;

    // Port widths fixed by the interface
    localparam int unsigned PUSH_W   = 32;
    localparam int unsigned CFG_W    = 11;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned REG_IW   = APB_AW - 2;

    // Register map (word index)
    localparam logic [REG_IW-1:0] REG_INIT_CAP = 1'b0;

    // Reset value of the initial capacity register
    localparam logic [CFG_W-1:0] INIT_CAP_RST = 11'd10;

    // Operation codes
    typedef logic t_op;
    localparam t_op OP_PUSH = 1'b0;
    localparam t_op OP_POP  = 1'b1;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

/* rtl/core/ras_ram.sv */
module ras_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ras_resize.sv */
module ras_resize
    import ras_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [$clog2(DEPTH+1)-1:0] i_cap,
    input  logic                       i_grown,
    output logic [$clog2(DEPTH+1)-1:0] o_cap,
    output logic                       o_grown
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = CW + 3;

    logic [XW-1:0] w_cap4;
    logic [XW-1:0] w_cnt5;
    logic [XW-1:0] w_cap_x;
    logic [CW:0]   w_cap_up;
    logic          w_grow;
    logic          w_shrink;

    // count >= floor(4c/5)  <=>  4c < 5n + 5
    // count <= floor(c/5)   <=>  5n <= c
    assign w_cap4  = XW'(i_cap) << 2;
    assign w_cnt5  = (XW'(i_count) << 2) + XW'(i_count);
    assign w_cap_x = XW'(i_cap);
    assign w_grow   = w_cap4 < (w_cnt5 + XW'(5));
    assign w_shrink = (w_cnt5 <= w_cap_x) && i_grown;

    // floor(3c/2) = c + floor(c/2)
    assign w_cap_up = (CW+1)'(i_cap) + (CW+1)'(i_cap >> 1);

    always_comb begin
        o_cap   = i_cap;
        o_grown = i_grown;
        if (w_grow) begin
            o_cap   = (w_cap_up > (CW+1)'(DEPTH)) ? CW'(DEPTH) : w_cap_up[CW-1:0];
            o_grown = 1'b1;
        end else if (w_shrink) begin
            o_cap = i_cap >> 1;
        end
    end

endmodule

/* rtl/core/resizable_array_stack_unit.sv */
// LIFO stack over a DEPTH-entry single-port RAM with a logical capacity that
// tracks the fill level. Each input word is a push (operation 0) or a pop
// (operation 1); each produces exactly one result word carrying status, the
// popped value, capacity, item count and the largest capacity seen after any
// push. A push is refused (status full) when the count has reached the
// capacity; a pop on an empty stack returns 0 with status empty. After every
// successful push or pop the capacity grows to floor(3c/2) (capped at DEPTH)
// when count >= floor(4c/5), or halves when count <= floor(c/5) once it has
// grown before. The state is updated when a word is accepted and the RAM is
// accessed in that same cycle; the result then passes through stage s1, which
// waits for the RAM read data, and leaves through the output register. One word
// is accepted per clock as long as results are taken; the single RAM port, one
// access per operation, sets that rate. Writing initial_capacity (APB address
// 0) restarts the stack: count, grown flag and peak return to zero and the
// capacity takes the new value, capped at DEPTH. Write it only while the block
// is idle.
module resizable_array_stack_unit
    import ras_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input words
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_operation,
    input  logic signed [PUSH_W-1:0]   i_push_value,
    // result words
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic signed [PUSH_W-1:0]   o_pop_value,
    output logic [$clog2(DEPTH+1)-1:0] o_capacity,
    output logic [$clog2(DEPTH+1)-1:0] o_item_count,
    output logic [$clog2(DEPTH+1)-1:0] o_largest_capacity,
    // APB config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int unsigned CW = $clog2(DEPTH + 1);   // count/capacity width
    localparam int unsigned AW = $clog2(DEPTH);       // RAM address width
    localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;

    // ---------------------------------------------------------------------
    // Config register
    // ---------------------------------------------------------------------
    logic [CFG_W-1:0] r_init_val;
    logic             w_cfg_hit;
    logic [EW-1:0]    w_cfg_ext;
    logic [CW-1:0]    w_cfg_cap;

    assign pready    = 1'b1;
    assign w_cfg_hit = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1:2] == REG_INIT_CAP);
    assign w_cfg_ext = EW'(pwdata[CFG_W-1:0]);
    assign w_cfg_cap = (w_cfg_ext > EW'(DEPTH)) ? CW'(DEPTH) : w_cfg_ext[CW-1:0];
    assign prdata    = (paddr[APB_AW-1:2] == REG_INIT_CAP) ? APB_DW'(r_init_val)
                                                           : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_val <= INIT_CAP_RST;
        end else if (w_cfg_hit) begin
            r_init_val <= pwdata[CFG_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Stack state
    // ---------------------------------------------------------------------
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_cap;
    logic          r_grown;
    logic [CW-1:0] r_peak;

    logic          w_accept;
    logic          w_is_push;
    logic          w_push_ok;
    logic          w_pop_ok;
    logic [CW-1:0] w_count_nx;
    logic [CW-1:0] w_cap_rs;
    logic          w_grown_rs;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_cap;
    logic          n_grown;
    logic [CW-1:0] n_peak;
    t_status       w_status;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_is_push = (i_operation == OP_PUSH);
    assign w_push_ok = w_is_push && (r_count < r_cap) && (r_count < CW'(DEPTH));
    assign w_pop_ok  = !w_is_push && (r_count != '0);

    always_comb begin
        w_count_nx = r_count;
        if (w_push_ok) begin
            w_count_nx = r_count + 1'b1;
        end else if (w_pop_ok) begin
            w_count_nx = r_count - 1'b1;
        end
    end

    ras_resize #(
        .DEPTH   (DEPTH)
    ) u_resize (
        .i_count (w_count_nx),
        .i_cap   (r_cap),
        .i_grown (r_grown),
        .o_cap   (w_cap_rs),
        .o_grown (w_grown_rs)
    );

    always_comb begin
        n_count = w_count_nx;
        n_cap   = r_cap;
        n_grown = r_grown;
        if (w_push_ok || w_pop_ok) begin
            n_cap   = w_cap_rs;
            n_grown = w_grown_rs;
        end
        // peak follows every push, refused or not
        n_peak = r_peak;
        if (w_is_push && (n_cap > r_peak)) begin
            n_peak = n_cap;
        end
        if (w_is_push) begin
            w_status = w_push_ok ? ST_OK : ST_FULL;
        end else begin
            w_status = w_pop_ok ? ST_OK : ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CW'(INIT_CAP_RST);
            r_grown <= 1'b0;
            r_peak  <= '0;
        end else if (w_cfg_hit) begin
            r_count <= '0;
            r_cap   <= w_cfg_cap;
            r_grown <= 1'b0;
            r_peak  <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_cap   <= n_cap;
            r_grown <= n_grown;
            r_peak  <= n_peak;
        end
    end

    // ---------------------------------------------------------------------
    // Item RAM: push writes at count, pop reads at count-1
    // ---------------------------------------------------------------------
    logic [AW-1:0]         w_ram_addr;
    logic [CW-1:0]         w_top;
    logic [VALUE_BITS-1:0] w_ram_wdata;
    logic [VALUE_BITS-1:0] w_ram_rdata;
    logic [PUSH_W-1:0]     w_rd_ext;

    assign w_top      = r_count - 1'b1;
    assign w_ram_addr = w_is_push ? r_count[AW-1:0] : w_top[AW-1:0];

    generate
        if (VALUE_BITS <= PUSH_W) begin : g_narrow
            assign w_ram_wdata = i_push_value[VALUE_BITS-1:0];
            assign w_rd_ext    = PUSH_W'(signed'(w_ram_rdata));
        end else begin : g_wide
            assign w_ram_wdata = VALUE_BITS'(i_push_value);
            assign w_rd_ext    = w_ram_rdata[PUSH_W-1:0];
        end
    endgenerate

    ras_ram #(
        .WIDTH   (VALUE_BITS),
        .DEPTH   (DEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_push_ok),
        .i_re    (w_accept && w_pop_ok),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // ---------------------------------------------------------------------
    // Pipeline: s1 waits for RAM read data, then the output register
    // ---------------------------------------------------------------------
    logic          r_s1_valid;
    t_status       r_s1_status;
    logic          r_s1_pop;
    logic [CW-1:0] r_s1_cap;
    logic [CW-1:0] r_s1_count;
    logic [CW-1:0] r_s1_peak;
    logic          w_s1_adv;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [PUSH_W-1:0] r_out_value;
    logic [CW-1:0]     r_out_cap;
    logic [CW-1:0]     r_out_count;
    logic [CW-1:0]     r_out_peak;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    // RAM read data holds while s1 stalls since no new word gets in
    assign o_in_ready = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_pop    <= w_pop_ok;
            r_s1_cap    <= n_cap;
            r_s1_count  <= n_count;
            r_s1_peak   <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_value  <= r_s1_pop ? w_rd_ext : '0;
            r_out_cap    <= r_s1_cap;
            r_out_count  <= r_s1_count;
            r_out_peak   <= r_s1_peak;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_pop_value        = r_out_value;
    assign o_capacity         = r_out_cap;
    assign o_item_count       = r_out_count;
    assign o_largest_capacity = r_out_peak;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= r_cap) && (r_cap <= CW'(DEPTH)))
        else $error("item count above capacity");

    a_peak_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_push && !w_cfg_hit) |=> (r_peak >= r_cap))
        else $error("peak capacity below capacity after push");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_pop_ok && !w_cfg_hit) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not decrement count");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("word accepted while pipeline stalled");

    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push_ok && w_pop_ok))
        else $error("push and pop both granted");

endmodule
